>>> design/pfc_pkg.sv
// Shared types and codes for the precedence function closure block.
package pfc_pkg;

	localparam int NodeSlots = 32;
	localparam int OpsLimit  = 16;

	typedef enum logic [1:0] {
		REL_NONE    = 2'd0,
		REL_LESS    = 2'd1,
		REL_EQUAL   = 2'd2,
		REL_GREATER = 2'd3
	} rel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CLOSE,
		ST_EMIT
	} state_t;

	localparam logic [0:0] REG_OP_COUNT = 1'b0;

	typedef struct packed {
		logic       wr_edge;
		logic       load_reach;
		logic       step;
		logic       emit_load;
		logic [4:0] idx;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [5:0] nodes;
	} status_t;

endpackage

>>> design/pfc_ctrl.sv
// Controller state machine: entry loading, closure pivots and result sequencing.
module pfc_ctrl
	import pfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  logic    last_entry,
	output logic    result_valid,
	input  logic    result_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic [4:0] nodes_m1;
	logic       cnt_end;
	logic       emit_ok;

	assign nodes_m1 = 5'(status.nodes - 6'd1);
	assign cnt_end  = (cnt_q == nodes_m1);
	assign emit_ok  = !out_valid_q || result_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && last_entry) state_d = ST_LOAD;
			end
			ST_LOAD:  state_d = ST_CLOSE;
			ST_CLOSE: begin
				if (cnt_end) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_ok && cnt_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready     = 1'b0;
		cmd            = '0;
		cmd.idx        = cnt_q;
		cmd.last       = cnt_end;
		unique case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.wr_edge = item_valid;
			end
			ST_LOAD:  cmd.load_reach = 1'b1;
			ST_CLOSE: cmd.step = 1'b1;
			ST_EMIT:  cmd.emit_load = emit_ok;
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_load) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
			if (state_q == ST_LOAD) begin
				cnt_q <= '0;
			end else if (cmd.step || cmd.emit_load) begin
				cnt_q <= cnt_end ? 5'd0 : cnt_q + 5'd1;
			end
		end
	end

endmodule

>>> design/pfc_datapath.sv
// Datapath: edge store, reach matrix with pivot update, and the result register.
module pfc_datapath
	import pfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  ops_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic [3:0]  row_index,
	input  logic [3:0]  col_index,
	input  logic [1:0]  relation,
	output logic [3:0]  node_index,
	output logic        is_g_side,
	output logic [5:0]  reach_count,
	output logic [31:0] reach_row,
	output logic        last_result
);

	logic [31:0] edge_q  [NodeSlots];
	logic [31:0] reach_q [NodeSlots];
	logic [32:0] mask_full;
	logic [31:0] mask;
	logic [5:0]  nodes;
	logic [4:0]  fnode;
	logic [4:0]  gnode;
	logic        in_range;
	logic [31:0] pivot_row;
	logic [31:0] sel_row;
	rel_t        rel;

	assign nodes        = {ops_n, 1'b0};
	assign status.nodes = nodes;
	assign mask_full    = (33'd1 << nodes) - 33'd1;
	assign mask         = mask_full[31:0];

	assign rel      = rel_t'(relation);
	assign in_range = ({1'b0, row_index} < ops_n) && ({1'b0, col_index} < ops_n);
	assign fnode    = {1'b0, row_index};
	assign gnode    = ops_n + {1'b0, col_index};

	assign pivot_row = reach_q[cmd.idx];
	assign sel_row   = reach_q[cmd.idx];

	function automatic logic [5:0] pop32(input logic [31:0] v);
		logic [2:0] nib [8];
		logic [5:0] sum;
		for (int b = 0; b < 8; b++) begin
			nib[b] = 3'(v[4*b]) + 3'(v[4*b+1]) + 3'(v[4*b+2]) + 3'(v[4*b+3]);
		end
		sum = '0;
		for (int b = 0; b < 8; b++) begin
			sum = sum + 6'(nib[b]);
		end
		return sum;
	endfunction

	// Edges persist across runs; only reset clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NodeSlots; i++) edge_q[i] <= '0;
		end else if (cmd.wr_edge && in_range) begin
			if (rel == REL_GREATER || rel == REL_EQUAL) edge_q[fnode][gnode] <= 1'b1;
			if (rel == REL_LESS || rel == REL_EQUAL) edge_q[gnode][fnode] <= 1'b1;
		end
	end

	// Reach matrix: seeded with self plus masked edges, then one pivot per cycle.
	always_ff @(posedge clk) begin
		if (cmd.load_reach) begin
			for (int i = 0; i < NodeSlots; i++) begin
				reach_q[i] <= (edge_q[i] & mask) | (32'd1 << i);
			end
		end else if (cmd.step) begin
			for (int i = 0; i < NodeSlots; i++) begin
				if (reach_q[i][cmd.idx]) reach_q[i] <= reach_q[i] | pivot_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			is_g_side   <= (cmd.idx >= ops_n);
			node_index  <= (cmd.idx >= ops_n) ? 4'(cmd.idx - ops_n) : cmd.idx[3:0];
			reach_count <= pop32(sel_row);
			reach_row   <= sel_row;
			last_result <= cmd.last;
		end
	end

endmodule

>>> design/precedence_function_closure.sv
// Top level of the precedence function closure block: config register, controller, datapath.
// Matrix entries are taken only while the block is idle; they may arrive back to back.
// After the last entry: a seeding step, then 2n closure pivots (one pivot per cycle on
// the reach matrix), then 2n results at up to one per cycle as the sink allows.
// Reset clears the edge store at once and sets op_count to 16; no clearing pass is run.
module precedence_function_closure
	import pfc_pkg::*;
#(
	parameter int MAX_OPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Matrix entry channel.
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [3:0]  row_index,
	input  logic [3:0]  col_index,
	input  logic [1:0]  relation,
	input  logic        last_entry,
	// Result channel.
	output logic        result_valid,
	input  logic        result_ready,
	output logic [3:0]  node_index,
	output logic        is_g_side,
	output logic [5:0]  reach_count,
	output logic [31:0] reach_row,
	output logic        last_result
);

	// The operator count is bounded by the parameter and by the 32 node bits of a row.
	localparam int OpsMax = (MAX_OPS > OpsLimit) ? OpsLimit : MAX_OPS;

	logic [4:0] op_count_q;
	logic [4:0] ops_n;
	cmd_t       cmd;
	status_t    status;

	assign pready = 1'b1;

	// A register write lands when the access phase of a write transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_count_q <= 5'd16;
		end else if (psel && penable && pwrite && paddr[2] == REG_OP_COUNT) begin
			op_count_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr[2] == REG_OP_COUNT) ? {27'd0, op_count_q} : 32'd0;

	// A zero count acts as one operator; anything above the bound is clamped to it.
	always_comb begin
		if (op_count_q == 5'd0) ops_n = 5'd1;
		else if (op_count_q > 5'(OpsMax)) ops_n = 5'(OpsMax);
		else ops_n = op_count_q;
	end

	// The controller sequences the phases; the datapath owns all matrix storage.
	pfc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.last_entry   (last_entry),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	pfc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ops_n       (ops_n),
		.cmd         (cmd),
		.status      (status),
		.row_index   (row_index),
		.col_index   (col_index),
		.relation    (relation),
		.node_index  (node_index),
		.is_g_side   (is_g_side),
		.reach_count (reach_count),
		.reach_row   (reach_row),
		.last_result (last_result)
	);

endmodule

>>> test/precedence_function_closure_test.sv
// Self-checking testbench for the precedence function closure block.
module precedence_function_closure_test;
	import pfc_pkg::*;

	localparam int          MAX_OPS      = 16;
	localparam int          RANDOM_ITEMS = 400;
	// Seeding, closure and some slack before the block counts as idle.
	localparam int          CLOSE_SETTLE = 80;
	localparam int          HOLD_CYCLES  = 600;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [3:0] row;
		logic [3:0] col;
		rel_t       rel;
		logic       last;
	} matrix_entry_t;

	typedef struct packed {
		logic [3:0]  node;
		logic        g_side;
		logic [5:0]  count;
		logic [31:0] row;
		logic        last;
	} node_reach_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_TRICKLE
	} sink_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [3:0]  row_index = '0;
	logic [3:0]  col_index = '0;
	logic [1:0]  relation = '0;
	logic        last_entry = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [3:0]  node_index;
	logic        is_g_side;
	logic [5:0]  reach_count;
	logic [31:0] reach_row;
	logic        last_result;

	precedence_function_closure #(
		.MAX_OPS(MAX_OPS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.row_index(row_index),
		.col_index(col_index),
		.relation(relation),
		.last_entry(last_entry),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.node_index(node_index),
		.is_g_side(is_g_side),
		.reach_count(reach_count),
		.reach_row(reach_row),
		.last_result(last_result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Our own copy of the block's state: the operator count register and the edge store.
	logic [4:0]    op_count_shadow = 5'd16;
	logic [31:0]   edge_store [NodeSlots];
	matrix_entry_t pending_entries [$];
	node_reach_t   reach_results_due [$];
	int unsigned   error_total = 0;

	initial begin
		foreach (edge_store[k])
			edge_store[k] = '0;
	end

	// Out-of-range counts are folded the same way the hardware folds them.
	function automatic int effective_ops(logic [4:0] setting);
		int n;
		n = setting;
		if (n < 1)
			n = 1;
		if (n > MAX_OPS)
			n = MAX_OPS;
		if (n > OpsLimit)
			n = OpsLimit;
		return n;
	endfunction

	// Stores one matrix entry as graph edges and, on the final entry, computes the
	// reachability of every node and queues the 2n results in emission order.
	function automatic void add_entry_and_close(logic [3:0] row, logic [3:0] col, rel_t rel,
			logic last);
		int          n;
		int          nodes;
		logic [31:0] mask;
		logic [31:0] reach;
		logic [31:0] prev;
		node_reach_t res;
		n = effective_ops(op_count_shadow);
		if (row < n && col < n) begin
			if (rel == REL_GREATER || rel == REL_EQUAL)
				edge_store[row] |= 32'd1 << (n + col);
			if (rel == REL_LESS || rel == REL_EQUAL)
				edge_store[n + col] |= 32'd1 << row;
		end
		if (!last)
			return;
		nodes = 2 * n;
		mask = (nodes >= 32) ? '1 : ((32'd1 << nodes) - 32'd1);
		for (int s = 0; s < nodes; s++) begin
			reach = 32'd1 << s;
			// Grow the set until a full sweep adds nothing; cycles simply saturate.
			do begin
				prev = reach;
				for (int k = 0; k < nodes; k++)
					if (reach[k])
						reach |= edge_store[k] & mask;
			end while (reach != prev);
			res.node = (s >= n) ? 4'(s - n) : 4'(s);
			res.g_side = (s >= n);
			res.count = 6'($countones(reach));
			res.row = reach;
			res.last = (s + 1 == nodes);
			reach_results_due.push_back(res);
		end
	endfunction

	// Sender: presents queued entries in bursts of random length with random gaps.
	// A transfer happens at an edge where item_valid and item_ready are both high.
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		matrix_entry_t nxt;
		if (arst_n && item_valid && item_ready)
			add_entry_and_close(row_index, col_index, rel_t'(relation), last_entry);
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (gap_left != 0 || pending_entries.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				item_valid <= 1'b0;
			end else begin
				nxt = pending_entries.pop_front();
				row_index <= nxt.row;
				col_index <= nxt.col;
				relation <= nxt.rel;
				last_entry <= nxt.last;
				item_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// A third of the bursts run straight into the next one with no gap.
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Long receiver hold-off, counted here, so the block backs up into its input.
	logic        hold_req = 1'b0;
	logic        hold_taken = 1'b0;
	logic        sink_hold = 1'b0;
	int unsigned hold_left = 0;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
		end else if (hold_req && !hold_taken) begin
			hold_left = HOLD_CYCLES;
			hold_taken = 1'b1;
		end
		sink_hold <= (hold_left != 0);
	end

	// Receiver: checks every result transfer against the oldest expectation, then picks
	// result_ready for the next cycle from a stall pattern that changes now and then.
	sink_mode_t  sink_mode = SINK_OPEN;
	int unsigned sink_mode_left = 0;
	int unsigned sink_tick = 0;

	always @(posedge clk) begin
		node_reach_t want;
		logic        take;
		if (arst_n && result_valid && result_ready) begin
			if (reach_results_due.size() == 0) begin
				$error("result transfer with nothing expected: node %0d g %0b row %08h",
					node_index, is_g_side, reach_row);
				error_total++;
			end else begin
				want = reach_results_due.pop_front();
				if (node_index !== want.node) begin
					$error("node_index expected %0d got %0d", want.node, node_index);
					error_total++;
				end
				if (is_g_side !== want.g_side) begin
					$error("is_g_side expected %0b got %0b", want.g_side, is_g_side);
					error_total++;
				end
				if (reach_count !== want.count) begin
					$error("reach_count expected %0d got %0d", want.count, reach_count);
					error_total++;
				end
				if (reach_row !== want.row) begin
					$error("reach_row expected %08h got %08h", want.row, reach_row);
					error_total++;
				end
				if (last_result !== want.last) begin
					$error("last_result expected %0b got %0b", want.last, last_result);
					error_total++;
				end
			end
		end
		sink_tick++;
		if (sink_mode_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_mode_left = $urandom_range(20, 200);
		end else begin
			sink_mode_left--;
		end
		case (sink_mode)
			SINK_OPEN: begin
				take = 1'b1;
			end
			SINK_COIN: begin
				take = 1'($urandom_range(0, 1));
			end
			SINK_SPARSE: begin
				take = ($urandom_range(0, 4) == 0);
			end
			default: begin
				take = (sink_tick % 4 == 0);
			end
		endcase
		result_ready <= take && !sink_hold;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	int unsigned cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("precedence_function_closure_test: FAIL");
			$finish;
		end
	end

	// Register write through the APB-style port: setup cycle, then access cycle.
	// The shadow copy follows once the access edge has passed.
	task automatic set_op_count(logic [4:0] setting);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'({REG_OP_COUNT, 2'b00});
		pwdata <= {27'($urandom), setting};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		op_count_shadow = setting;
	endtask

	task automatic push_entry(logic [3:0] row, logic [3:0] col, rel_t rel, logic last);
		matrix_entry_t ent;
		ent.row = row;
		ent.col = col;
		ent.rel = rel;
		ent.last = last;
		pending_entries.push_back(ent);
	endtask

	// Waits until every entry has been taken and every result has come back, then lets
	// the closure latency pass in case the last entry only loaded the edge store.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_entries.size() != 0 || item_valid || reach_results_due.size() != 0);
		repeat (CLOSE_SETTLE) @(negedge clk);
	endtask

	initial begin
		int         random_items;
		int         phase;
		int         pick;
		int         n;
		int         runs;
		int         len;
		bit         broken;
		bit         in_range;
		logic [4:0] setting;
		logic [3:0] row;
		logic [3:0] col;
		logic       last;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. At the reset count of 16: corner indices, every relation,
		// a relation of none, and a last entry that starts the first closure.
		push_entry(4'd0, 4'd0, REL_GREATER, 1'b0);
		push_entry(4'd15, 4'd15, REL_LESS, 1'b0);
		push_entry(4'd3, 4'd5, REL_EQUAL, 1'b0);
		push_entry(4'd7, 4'd2, REL_NONE, 1'b0);
		push_entry(4'd15, 4'd0, REL_GREATER, 1'b0);
		push_entry(4'd0, 4'd15, REL_LESS, 1'b1);
		wait_idle();
		// Smallest graph: an equal relation makes a two-node cycle. Then an entry whose
		// row is out of range still starts a run when it carries the last flag.
		set_op_count(5'd1);
		push_entry(4'd0, 4'd0, REL_EQUAL, 1'b1);
		push_entry(4'd1, 4'd0, REL_GREATER, 1'b1);
		wait_idle();
		// A count of zero acts as one.
		set_op_count(5'd0);
		push_entry(4'd15, 4'd15, REL_NONE, 1'b1);
		wait_idle();
		// The largest register value folds down to the operator limit.
		set_op_count(5'd31);
		push_entry(4'd15, 4'd15, REL_GREATER, 1'b1);
		wait_idle();
		// Entries loaded at one count and closed at another: the node bits keep the
		// placement of the count in force when they were stored.
		set_op_count(5'd5);
		push_entry(4'd4, 4'd4, REL_GREATER, 1'b0);
		push_entry(4'd2, 4'd3, REL_LESS, 1'b0);
		push_entry(4'd1, 4'd1, REL_EQUAL, 1'b0);
		wait_idle();
		set_op_count(5'd3);
		push_entry(4'd9, 4'd9, REL_NONE, 1'b1);
		wait_idle();
		set_op_count(5'd16);
		push_entry(4'd10, 4'd6, REL_EQUAL, 1'b1);
		wait_idle();

		// Random part: mostly well-formed partial matrices that end in a last entry,
		// with some out-of-range indices, stray last flags and runs left unfinished.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (phase == 4)
				setting = 5'd16;
			else if (pick == 0)
				setting = 5'($urandom_range(0, 1));
			else if (pick == 1)
				setting = 5'($urandom_range(16, 31));
			else
				setting = 5'($urandom_range(1, 16));
			set_op_count(setting);
			n = effective_ops(setting);
			// One phase stacks several runs behind a long receiver hold-off.
			if (phase == 4) begin
				hold_req = 1'b1;
				runs = 4;
			end else begin
				runs = ($urandom_range(0, 4) == 0) ? 2 : 1;
			end
			for (int r = 0; r < runs; r++) begin
				len = $urandom_range(1, (3 * n + 2 < 40) ? 3 * n + 2 : 40);
				broken = (phase != 4) && ($urandom_range(0, 9) == 0);
				for (int e = 0; e < len; e++) begin
					in_range = ($urandom_range(0, 9) != 0);
					row = in_range ? 4'($urandom_range(0, n - 1)) : 4'($urandom_range(0, 15));
					col = in_range ? 4'($urandom_range(0, n - 1)) : 4'($urandom_range(0, 15));
					last = ((e == len - 1) && !broken) || ($urandom_range(0, 39) == 0);
					push_entry(row, col, rel_t'($urandom_range(0, 3)), last);
					random_items++;
				end
			end
			wait_idle();
			phase++;
		end

		if (error_total == 0)
			$display("precedence_function_closure_test: PASS");
		else
			$display("precedence_function_closure_test: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
design/pfc_pkg.sv
design/pfc_ctrl.sv
design/pfc_datapath.sv
design/precedence_function_closure.sv
test/precedence_function_closure_test.sv
